// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sensor sequencer RTL.
// Needs nothing else; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at the current edge whenever the trigger holds.
`define HTS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define HTS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== sv/hts_pkg.sv =====
// Shared types, codes and conversion constants for the sensor sequencer.
// Has no dependencies; used by every module of the block.
package hts_pkg;

   // Request codes carried by an input item.
   typedef enum logic [1:0] {
      REQ_RESET     = 2'd0,
      REQ_CONFIGURE = 2'd1,
      REQ_MEASURE   = 2'd2,
      REQ_COMPLETE  = 2'd3
   } req_kind_type;

   // Result codes carried by a result item.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ISSUE = 3'd1,
      KIND_MEAS  = 3'd2,
      KIND_CFG   = 3'd3,
      KIND_BUSY  = 3'd4
   } result_kind_type;

   // Transaction sequence steps.
   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_RST_CMD   = 4'd1,
      ST_CFG_CMD   = 4'd2,
      ST_CFG_READ  = 4'd3,
      ST_CFG_WRITE = 4'd4,
      ST_T_CMD     = 4'd5,
      ST_T_READ    = 4'd6,
      ST_H_CMD     = 4'd7,
      ST_H_READ    = 4'd8
   } step_type;

   // Sensor command bytes.
   localparam logic [7:0] CMD_TRIG_T  = 8'hE3;
   localparam logic [7:0] CMD_TRIG_RH = 8'hE5;
   localparam logic [7:0] CMD_REG_WR  = 8'hE6;
   localparam logic [7:0] CMD_REG_RD  = 8'hE7;
   localparam logic [7:0] CMD_RESET   = 8'hFE;

   // User register bits that survive a resolution update.
   localparam logic [7:0] REG_KEEP_MASK = 8'h7E;

   // Transfer lengths in bytes.
   localparam logic [1:0] LEN_CMD  = 2'd1;
   localparam logic [1:0] LEN_REG  = 2'd2;
   localparam logic [1:0] LEN_MEAS = 2'd3;

   // Configuration register indexes and reset values.
   localparam logic CSR_IDX_RESOLUTION = 1'b0;
   localparam logic CSR_IDX_DEVICE     = 1'b1;
   localparam logic [1:0] RES_MODE_RESET = 2'd0;
   localparam logic [6:0] DEV_ADDR_RESET = 7'h40;

   // Field widths.
   localparam int RAW_W      = 14;
   localparam int TEMP_W     = 15;
   localparam int HUM_W      = 14;
   localparam int TEMP_MAG_W = 18;
   localparam int HUM_MAG_W  = 13;
   localparam int TEMP_PROD_W = 27;
   localparam int HUM_PROD_W  = 21;
   localparam int TEMP_SCALED_W = 37;
   localparam int TEMP_RECIP_SHIFT = 23;

   // Temperature on the 14-bit reading r: (r*4393 - 19189760) / 6400.
   localparam logic [12:0] TEMP_GAIN = 13'd4393;
   localparam logic [TEMP_PROD_W-1:0] TEMP_OFFSET = 27'd19189760;
   localparam logic [RAW_W-1:0] TEMP_NEG_LIMIT = 14'd4368;
   // Reciprocal of 25 for the quotient after the shift by 8.
   localparam logic [18:0] TEMP_RECIP = 19'd335545;

   // Humidity on the 14-bit reading r: (r*125 - 98304) / 256.
   localparam logic [6:0] HUM_GAIN = 7'd125;
   localparam logic [HUM_PROD_W-1:0] HUM_OFFSET = 21'd98304;
   localparam logic [RAW_W-1:0] HUM_NEG_LIMIT = 14'd786;

   // Configuration as seen by the sequencer.
   typedef struct packed {
      logic [1:0] resolution_mode;
      logic [6:0] device_address;
   } cfg_type;

   // One item after the front conversion step.
   typedef struct packed {
      req_kind_type          kind;
      logic [7:0]            byte_high;
      logic [TEMP_MAG_W-1:0] temp_mag;
      logic                  temp_neg;
      logic [HUM_MAG_W-1:0]  hum_mag;
      logic                  hum_neg;
   } item_type;

endpackage

// ===== sv/hts_csr.sv =====
// APB-style configuration registers of the sensor sequencer.
// Depends on hts_pkg for register indexes, reset values and cfg_type.
module hts_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output hts_pkg::cfg_type   cfg
);

   logic [1:0] res_mode_ff;
   logic [1:0] res_mode_in;
   logic [6:0] dev_addr_ff;
   logic [6:0] dev_addr_in;
   logic       wr_en;

   // The word index sits in bit 2; byte-lane bits are ignored.
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register write decode.
   always_comb begin
      res_mode_in = res_mode_ff;
      dev_addr_in = dev_addr_ff;
      if (wr_en) begin
         case (paddr[2])
            hts_pkg::CSR_IDX_RESOLUTION: res_mode_in = pwdata[1:0];
            hts_pkg::CSR_IDX_DEVICE:     dev_addr_in = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_mode_ff <= hts_pkg::RES_MODE_RESET;
         dev_addr_ff <= hts_pkg::DEV_ADDR_RESET;
      end else begin
         res_mode_ff <= res_mode_in;
         dev_addr_ff <= dev_addr_in;
      end
   end

   // Read mux.
   always_comb begin
      case (paddr[2])
         hts_pkg::CSR_IDX_RESOLUTION: prdata = {30'd0, res_mode_ff};
         hts_pkg::CSR_IDX_DEVICE:     prdata = {25'd0, dev_addr_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg.resolution_mode = res_mode_ff;
   assign cfg.device_address  = dev_addr_ff;

endmodule

// ===== sv/hts_conv.sv =====
// Front conversion step: forms the 14-bit reading and the scaled magnitudes.
// Depends on hts_pkg for conversion constants and item_type.
module hts_conv (
   input  logic [1:0]         req_type,
   input  logic [7:0]         read_byte_high,
   input  logic [7:0]         read_byte_low,
   output hts_pkg::item_type  item
);

   logic [hts_pkg::RAW_W-1:0]       raw_word;
   logic [hts_pkg::TEMP_PROD_W-1:0] temp_prod;
   logic [hts_pkg::TEMP_PROD_W-1:0] temp_diff;
   logic                            temp_neg;
   logic [hts_pkg::HUM_PROD_W-1:0]  hum_prod;
   logic [hts_pkg::HUM_PROD_W-1:0]  hum_diff;
   logic                            hum_neg;

   // The two status bits of the low byte are dropped.
   assign raw_word = {read_byte_high, read_byte_low[7:2]};

   // Temperature: scaled reading minus offset, kept as sign and magnitude.
   assign temp_prod = hts_pkg::TEMP_PROD_W'(raw_word) * hts_pkg::TEMP_PROD_W'(hts_pkg::TEMP_GAIN);
   assign temp_neg  = (raw_word <= hts_pkg::TEMP_NEG_LIMIT);
   assign temp_diff = temp_neg ? (hts_pkg::TEMP_OFFSET - temp_prod)
                               : (temp_prod - hts_pkg::TEMP_OFFSET);

   // Humidity: same scheme with its own gain and offset.
   assign hum_prod = hts_pkg::HUM_PROD_W'(raw_word) * hts_pkg::HUM_PROD_W'(hts_pkg::HUM_GAIN);
   assign hum_neg  = (raw_word <= hts_pkg::HUM_NEG_LIMIT);
   assign hum_diff = hum_neg ? (hts_pkg::HUM_OFFSET - hum_prod)
                             : (hum_prod - hts_pkg::HUM_OFFSET);

   // The shift by 8 is the power-of-two part of each divisor.
   assign item.kind      = hts_pkg::req_kind_type'(req_type);
   assign item.byte_high = read_byte_high;
   assign item.temp_mag  = temp_diff[hts_pkg::TEMP_MAG_W+7:8];
   assign item.temp_neg  = temp_neg;
   assign item.hum_mag   = hum_diff[hts_pkg::HUM_MAG_W+7:8];
   assign item.hum_neg   = hum_neg;

endmodule

// ===== sv/hts_seq.sv =====
// Transaction sequencer: step state, stored readings and the result register.
// Depends on hts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hts_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               stage_valid,
   input  hts_pkg::item_type                  item,
   input  hts_pkg::cfg_type                   cfg,
   output logic                               stage_advance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_result_kind,
   output logic                               rsp_xfer_is_read,
   output logic [1:0]                         rsp_xfer_length,
   output logic [6:0]                         rsp_xfer_address,
   output logic [7:0]                         rsp_xfer_command,
   output logic [7:0]                         rsp_xfer_register_value,
   output logic signed [hts_pkg::TEMP_W-1:0]  rsp_temperature_value,
   output logic signed [hts_pkg::HUM_W-1:0]   rsp_humidity_value
);

   hts_pkg::step_type        state_ff;
   hts_pkg::step_type        state_in;
   hts_pkg::result_kind_type kind_in;
   logic                     is_read_in;
   logic [1:0]               length_in;
   logic [6:0]               address_in;
   logic [7:0]               command_in;
   logic [7:0]               regval_in;

   logic signed [hts_pkg::TEMP_W-1:0] temp_ff;
   logic signed [hts_pkg::TEMP_W-1:0] temp_in;
   logic signed [hts_pkg::HUM_W-1:0]  hum_ff;
   logic signed [hts_pkg::HUM_W-1:0]  hum_in;

   logic [hts_pkg::TEMP_SCALED_W-1:0] temp_scaled;
   logic [hts_pkg::TEMP_W-2:0]        temp_quot;
   logic signed [hts_pkg::TEMP_W-1:0] temp_conv;
   logic signed [hts_pkg::HUM_W-1:0]  hum_conv;
   logic [7:0]                        new_regval;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   hts_pkg::result_kind_type          rsp_kind_ff;
   logic                              rsp_is_read_ff;
   logic [1:0]                        rsp_length_ff;
   logic [6:0]                        rsp_address_ff;
   logic [7:0]                        rsp_command_ff;
   logic [7:0]                        rsp_regval_ff;

   // The item moves on when the result register is empty or being drained.
   assign stage_advance = stage_valid && (!rsp_valid_ff || rsp_ready);

   // Temperature quotient by 25 through a reciprocal multiply, then the sign.
   assign temp_scaled = hts_pkg::TEMP_SCALED_W'(item.temp_mag)
                      * hts_pkg::TEMP_SCALED_W'(hts_pkg::TEMP_RECIP);
   assign temp_quot   = temp_scaled[hts_pkg::TEMP_RECIP_SHIFT+hts_pkg::TEMP_W-2:
                                    hts_pkg::TEMP_RECIP_SHIFT];
   assign temp_conv   = item.temp_neg ? -$signed({1'b0, temp_quot})
                                      : $signed({1'b0, temp_quot});
   assign hum_conv    = item.hum_neg ? -$signed({1'b0, item.hum_mag})
                                     : $signed({1'b0, item.hum_mag});

   // Resolution bit 0 lands in register bit 0 and bit 1 in register bit 7.
   assign new_regval = (item.byte_high & hts_pkg::REG_KEEP_MASK)
                     | {cfg.resolution_mode[1], 6'd0, cfg.resolution_mode[0]};

   // Next step.
   always_comb begin
      state_in = state_ff;
      if (item.kind != hts_pkg::REQ_COMPLETE) begin
         if (state_ff == hts_pkg::ST_IDLE) begin
            case (item.kind)
               hts_pkg::REQ_RESET:     state_in = hts_pkg::ST_RST_CMD;
               hts_pkg::REQ_CONFIGURE: state_in = hts_pkg::ST_CFG_CMD;
               default:                state_in = hts_pkg::ST_T_CMD;
            endcase
         end
      end else begin
         case (state_ff)
            hts_pkg::ST_RST_CMD:   state_in = hts_pkg::ST_IDLE;
            hts_pkg::ST_CFG_CMD:   state_in = hts_pkg::ST_CFG_READ;
            hts_pkg::ST_CFG_READ:  state_in = hts_pkg::ST_CFG_WRITE;
            hts_pkg::ST_CFG_WRITE: state_in = hts_pkg::ST_IDLE;
            hts_pkg::ST_T_CMD:     state_in = hts_pkg::ST_T_READ;
            hts_pkg::ST_T_READ:    state_in = hts_pkg::ST_H_CMD;
            hts_pkg::ST_H_CMD:     state_in = hts_pkg::ST_H_READ;
            hts_pkg::ST_H_READ:    state_in = hts_pkg::ST_IDLE;
            default:               state_in = hts_pkg::ST_IDLE;
         endcase
      end
   end

   // Result fields and reading updates for the current step.
   always_comb begin
      kind_in    = hts_pkg::KIND_NONE;
      is_read_in = 1'b0;
      length_in  = 2'd0;
      command_in = 8'd0;
      regval_in  = 8'd0;
      temp_in    = temp_ff;
      hum_in     = hum_ff;
      if (item.kind != hts_pkg::REQ_COMPLETE) begin
         if (state_ff != hts_pkg::ST_IDLE) begin
            kind_in = hts_pkg::KIND_BUSY;
         end else begin
            kind_in   = hts_pkg::KIND_ISSUE;
            length_in = hts_pkg::LEN_CMD;
            case (item.kind)
               hts_pkg::REQ_RESET:     command_in = hts_pkg::CMD_RESET;
               hts_pkg::REQ_CONFIGURE: command_in = hts_pkg::CMD_REG_RD;
               default:                command_in = hts_pkg::CMD_TRIG_T;
            endcase
         end
      end else begin
         case (state_ff)
            hts_pkg::ST_CFG_CMD: begin
               kind_in    = hts_pkg::KIND_ISSUE;
               is_read_in = 1'b1;
               length_in  = hts_pkg::LEN_CMD;
            end
            hts_pkg::ST_CFG_READ: begin
               kind_in    = hts_pkg::KIND_ISSUE;
               length_in  = hts_pkg::LEN_REG;
               command_in = hts_pkg::CMD_REG_WR;
               regval_in  = new_regval;
            end
            hts_pkg::ST_CFG_WRITE: begin
               kind_in = hts_pkg::KIND_CFG;
            end
            hts_pkg::ST_T_CMD, hts_pkg::ST_H_CMD: begin
               kind_in    = hts_pkg::KIND_ISSUE;
               is_read_in = 1'b1;
               length_in  = hts_pkg::LEN_MEAS;
            end
            hts_pkg::ST_T_READ: begin
               kind_in    = hts_pkg::KIND_ISSUE;
               length_in  = hts_pkg::LEN_CMD;
               command_in = hts_pkg::CMD_TRIG_RH;
               temp_in    = temp_conv;
            end
            hts_pkg::ST_H_READ: begin
               kind_in = hts_pkg::KIND_MEAS;
               hum_in  = hum_conv;
            end
            default: ;
         endcase
      end
      address_in = (kind_in == hts_pkg::KIND_ISSUE) ? cfg.device_address : 7'd0;
   end

   // Result register valid: set by an advancing item, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and stored readings.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hts_pkg::ST_IDLE;
         temp_ff      <= '0;
         hum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (stage_advance) begin
            state_ff <= state_in;
            temp_ff  <= temp_in;
            hum_ff   <= hum_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (stage_advance) begin
         rsp_kind_ff    <= kind_in;
         rsp_is_read_ff <= is_read_in;
         rsp_length_ff  <= length_in;
         rsp_address_ff <= address_in;
         rsp_command_ff <= command_in;
         rsp_regval_ff  <= regval_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result_kind         = rsp_kind_ff;
   assign rsp_xfer_is_read        = rsp_is_read_ff;
   assign rsp_xfer_length         = rsp_length_ff;
   assign rsp_xfer_address        = rsp_address_ff;
   assign rsp_xfer_command        = rsp_command_ff;
   assign rsp_xfer_register_value = rsp_regval_ff;
   assign rsp_temperature_value   = temp_ff;
   assign rsp_humidity_value      = hum_ff;

   // A request while a sequence runs leaves the step unchanged.
   `HTS_ASSERT_NEXT(a_busy_keeps_step, clock, reset,
      stage_advance && state_ff != hts_pkg::ST_IDLE && item.kind != hts_pkg::REQ_COMPLETE,
      state_ff == $past(state_ff) && rsp_kind_ff == hts_pkg::KIND_BUSY,
      "busy request changed the sequence step")

   // A request while idle always issues a transaction.
   `HTS_ASSERT_NEXT(a_idle_issues, clock, reset,
      stage_advance && state_ff == hts_pkg::ST_IDLE && item.kind != hts_pkg::REQ_COMPLETE,
      rsp_kind_ff == hts_pkg::KIND_ISSUE && state_ff != hts_pkg::ST_IDLE,
      "idle request did not start a sequence")

   // The humidity read completion ends the measurement.
   `HTS_ASSERT_NEXT(a_meas_done, clock, reset,
      stage_advance && state_ff == hts_pkg::ST_H_READ && item.kind == hts_pkg::REQ_COMPLETE,
      state_ff == hts_pkg::ST_IDLE && rsp_kind_ff == hts_pkg::KIND_MEAS,
      "measurement did not finish after the humidity read")

   // Transfer fields are zero unless a transaction is issued.
   `HTS_ASSERT_NOW(a_quiet_xfer, clock, reset,
      rsp_valid_ff && rsp_kind_ff != hts_pkg::KIND_ISSUE,
      !rsp_is_read_ff && rsp_length_ff == 2'd0 && rsp_address_ff == 7'd0
         && rsp_command_ff == 8'd0 && rsp_regval_ff == 8'd0,
      "transfer fields set on a result without a transaction")

endmodule

// ===== sv/humidity_temp_sensor_sequencer_core.sv =====
// Items pass the input register, then the result register once it is free.
// One item per cycle while rsp_ready holds; the path is the reading multiply at
// the input register and the reciprocal multiply in front of the result register.
// Reset (synchronous, active high) returns the sequence to idle, clears the
// stored readings and sets the resolution mode to 0 and the device address to 64.
module humidity_temp_sensor_sequencer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [7:0]                         req_read_byte_high,
   input  logic [7:0]                         req_read_byte_low,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_result_kind,
   output logic                               rsp_xfer_is_read,
   output logic [1:0]                         rsp_xfer_length,
   output logic [6:0]                         rsp_xfer_address,
   output logic [7:0]                         rsp_xfer_command,
   output logic [7:0]                         rsp_xfer_register_value,
   output logic signed [hts_pkg::TEMP_W-1:0]  rsp_temperature_value,
   output logic signed [hts_pkg::HUM_W-1:0]   rsp_humidity_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   hts_pkg::cfg_type  cfg;
   hts_pkg::item_type conv_item;
   hts_pkg::item_type stage_item_ff;
   logic              stage_valid_ff;
   logic              stage_valid_in;
   logic              stage_advance;
   logic              req_accept;

   // Configuration registers.
   hts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Reading scale and offset ahead of the input register.
   hts_conv u_conv (
      .req_type       (req_type),
      .read_byte_high (req_read_byte_high),
      .read_byte_low  (req_read_byte_low),
      .item           (conv_item)
   );

   // Input register: refills in the same cycle that its item moves on.
   assign req_ready  = !stage_valid_ff || stage_advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_item_ff <= conv_item;
      end
   end

   // Sequencer and result register.
   hts_seq u_seq (
      .clock                   (clock),
      .reset                   (reset),
      .stage_valid             (stage_valid_ff),
      .item                    (stage_item_ff),
      .cfg                     (cfg),
      .stage_advance           (stage_advance),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_xfer_is_read        (rsp_xfer_is_read),
      .rsp_xfer_length         (rsp_xfer_length),
      .rsp_xfer_address        (rsp_xfer_address),
      .rsp_xfer_command        (rsp_xfer_command),
      .rsp_xfer_register_value (rsp_xfer_register_value),
      .rsp_temperature_value   (rsp_temperature_value),
      .rsp_humidity_value      (rsp_humidity_value)
   );

endmodule

// ===== tb/sv/hts_sequencer_checker.sv =====
// Result checker for the humidity and temperature sensor sequencer.
// Watches the request, result and register ports, predicts every result and compares.
// Depends on hts_pkg for the request, result and step codes and the command bytes.
`timescale 1ns / 100ps

module hts_sequencer_checker
   import hts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_type,
   input  logic [7:0]               req_read_byte_high,
   input  logic [7:0]               req_read_byte_low,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [2:0]               rsp_result_kind,
   input  logic                     rsp_xfer_is_read,
   input  logic [1:0]               rsp_xfer_length,
   input  logic [6:0]               rsp_xfer_address,
   input  logic [7:0]               rsp_xfer_command,
   input  logic [7:0]               rsp_xfer_register_value,
   input  logic signed [TEMP_W-1:0] rsp_temperature_value,
   input  logic signed [HUM_W-1:0]  rsp_humidity_value,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   input  logic                     pready,
   output int                       fail_count,
   output int                       outstanding,
   output int                       item_count,
   output int                       reply_count,
   output int                       meas_count,
   output int                       busy_count
);

   // Register byte addresses.
   localparam logic [2:0] RES_ADDR = {CSR_IDX_RESOLUTION, 2'b00};
   localparam logic [2:0] DEV_ADDR = {CSR_IDX_DEVICE, 2'b00};

   // The two low bits of the second byte are sensor status, not data.
   localparam logic [7:0] STATUS_MASK = 8'hFC;

   // Conversion to signed 10.6 on the 16-bit raw word.
   localparam longint TEMP_SCALE = 17572;
   localparam longint TEMP_BIAS  = 307036160;
   localparam longint TEMP_DIV   = 102400;
   localparam longint HUM_SCALE  = 125;
   localparam longint HUM_BIAS   = 393216;
   localparam longint HUM_DIV    = 1024;

   typedef struct packed {
      result_kind_type   kind;
      logic              is_read;
      logic [1:0]        length;
      logic [6:0]        address;
      logic [7:0]        command;
      logic [7:0]        reg_value;
      logic [TEMP_W-1:0] temperature;
      logic [HUM_W-1:0]  humidity;
   } sensor_reply_type;

   // Shadow of the sequencer state and its registers.
   step_type           seq_step;
   logic signed [15:0] temp_latest;
   logic signed [15:0] hum_latest;
   logic [1:0]         res_mode;
   logic [6:0]         dev_addr;

   sensor_reply_type sequencer_replies[$];

   // Fill in a bus transaction on the current device address.
   function automatic sensor_reply_type issue_xfer(input logic is_read, input logic [1:0] len,
                                                   input logic [7:0] cmd,
                                                   input logic [7:0] regval);
      sensor_reply_type r;
      r = '0;
      r.kind      = KIND_ISSUE;
      r.is_read   = is_read;
      r.length    = len;
      r.address   = dev_addr;
      r.command   = cmd;
      r.reg_value = regval;
      return r;
   endfunction

   // Advance the transaction sequence by one item and return the result it causes.
   function automatic sensor_reply_type advance_sequence(input req_kind_type req,
                                                         input logic [7:0] hi,
                                                         input logic [7:0] lo);
      sensor_reply_type r;
      longint           raw;
      logic [7:0]       new_reg;
      r = '0;
      raw = longint'({hi, lo & STATUS_MASK});
      if (req != REQ_COMPLETE) begin
         if (seq_step != ST_IDLE) begin
            r.kind = KIND_BUSY;
         end else if (req == REQ_RESET) begin
            seq_step = ST_RST_CMD;
            r = issue_xfer(1'b0, LEN_CMD, CMD_RESET, 8'd0);
         end else if (req == REQ_CONFIGURE) begin
            seq_step = ST_CFG_CMD;
            r = issue_xfer(1'b0, LEN_CMD, CMD_REG_RD, 8'd0);
         end else begin
            seq_step = ST_T_CMD;
            r = issue_xfer(1'b0, LEN_CMD, CMD_TRIG_T, 8'd0);
         end
      end else begin
         case (seq_step)
            ST_RST_CMD: begin
               seq_step = ST_IDLE;
            end
            ST_CFG_CMD: begin
               seq_step = ST_CFG_READ;
               r = issue_xfer(1'b1, LEN_CMD, 8'd0, 8'd0);
            end
            ST_CFG_READ: begin
               // Resolution bit 1 lands in register bit 7, bit 0 in bit 0.
               new_reg = (hi & REG_KEEP_MASK) | {res_mode[1], 6'd0, res_mode[0]};
               seq_step = ST_CFG_WRITE;
               r = issue_xfer(1'b0, LEN_REG, CMD_REG_WR, new_reg);
            end
            ST_CFG_WRITE: begin
               seq_step = ST_IDLE;
               r.kind = KIND_CFG;
            end
            ST_T_CMD: begin
               seq_step = ST_T_READ;
               r = issue_xfer(1'b1, LEN_MEAS, 8'd0, 8'd0);
            end
            ST_T_READ: begin
               // Signed division truncates toward zero.
               temp_latest = 16'((raw * TEMP_SCALE - TEMP_BIAS) / TEMP_DIV);
               seq_step = ST_H_CMD;
               r = issue_xfer(1'b0, LEN_CMD, CMD_TRIG_RH, 8'd0);
            end
            ST_H_CMD: begin
               seq_step = ST_H_READ;
               r = issue_xfer(1'b1, LEN_MEAS, 8'd0, 8'd0);
            end
            ST_H_READ: begin
               hum_latest = 16'((raw * HUM_SCALE - HUM_BIAS) / HUM_DIV);
               seq_step = ST_IDLE;
               r.kind = KIND_MEAS;
            end
            default: begin
               seq_step = ST_IDLE;
            end
         endcase
      end
      r.temperature = temp_latest[TEMP_W-1:0];
      r.humidity    = hum_latest[HUM_W-1:0];
      return r;
   endfunction

   function automatic string describe(input sensor_reply_type r);
      return $sformatf("kind=%0d read=%0d len=%0d addr=%0d cmd=%02h reg=%02h temp=%0d hum=%0d",
                       r.kind, r.is_read, r.length, r.address, r.command, r.reg_value,
                       $signed(r.temperature), $signed(r.humidity));
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: MISMATCH %s", $realtime, msg);
   endfunction

   // Results are compared before new items are predicted; an item's result never
   // arrives in the cycle that accepts it.
   always @(posedge clock) begin : watch
      sensor_reply_type seen;
      sensor_reply_type want;
      if (reset) begin
         seq_step    = ST_IDLE;
         temp_latest = '0;
         hum_latest  = '0;
         res_mode    = RES_MODE_RESET;
         dev_addr    = DEV_ADDR_RESET;
         sequencer_replies.delete();
         fail_count  = 0;
         item_count  = 0;
         reply_count = 0;
         meas_count  = 0;
         busy_count  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.kind        = result_kind_type'(rsp_result_kind);
            seen.is_read     = rsp_xfer_is_read;
            seen.length      = rsp_xfer_length;
            seen.address     = rsp_xfer_address;
            seen.command     = rsp_xfer_command;
            seen.reg_value   = rsp_xfer_register_value;
            seen.temperature = rsp_temperature_value;
            seen.humidity    = rsp_humidity_value;
            reply_count++;
            if (seen.kind == KIND_MEAS) meas_count++;
            if (seen.kind == KIND_BUSY) busy_count++;
            if (sequencer_replies.size() == 0) begin
               note_failure({"result with no item outstanding: ", describe(seen)});
            end else begin
               want = sequencer_replies.pop_front();
               if (seen !== want)
                  note_failure({"expected ", describe(want), " got ", describe(seen)});
            end
         end
         // Register writes land only while no item is in flight.
         if (psel && penable && pwrite && pready) begin
            if (paddr == RES_ADDR) res_mode = pwdata[1:0];
            else if (paddr == DEV_ADDR) dev_addr = pwdata[6:0];
         end
         if (req_valid && req_ready) begin
            sequencer_replies.push_back(advance_sequence(req_kind_type'(req_type),
                                                         req_read_byte_high,
                                                         req_read_byte_low));
            item_count++;
         end
      end
      outstanding <= sequencer_replies.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the sensor sequencer testbench: clock, reset, stimulus and the verdict.
// Instantiates humidity_temp_sensor_sequencer_core and hts_sequencer_checker; uses hts_pkg.
`timescale 1ns / 100ps

module tb_top;
   import hts_pkg::*;

   localparam logic [2:0] RES_ADDR = {CSR_IDX_RESOLUTION, 2'b00};
   localparam logic [2:0] DEV_ADDR = {CSR_IDX_DEVICE, 2'b00};
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 900;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_type;
   logic [7:0]               req_read_byte_high;
   logic [7:0]               req_read_byte_low;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [2:0]               rsp_result_kind;
   logic                     rsp_xfer_is_read;
   logic [1:0]               rsp_xfer_length;
   logic [6:0]               rsp_xfer_address;
   logic [7:0]               rsp_xfer_command;
   logic [7:0]               rsp_xfer_register_value;
   logic signed [TEMP_W-1:0] rsp_temperature_value;
   logic signed [HUM_W-1:0]  rsp_humidity_value;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [2:0]               paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   int fail_count, outstanding, item_count, reply_count, meas_count, busy_count;
   int send_idle_pct, recv_idle_pct, noise_pct;
   int sent_items, csr_writes, quiet_cycles;

   humidity_temp_sensor_sequencer_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_read_byte_high(req_read_byte_high), .req_read_byte_low(req_read_byte_low),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_kind(rsp_result_kind),
      .rsp_xfer_is_read(rsp_xfer_is_read), .rsp_xfer_length(rsp_xfer_length),
      .rsp_xfer_address(rsp_xfer_address), .rsp_xfer_command(rsp_xfer_command),
      .rsp_xfer_register_value(rsp_xfer_register_value),
      .rsp_temperature_value(rsp_temperature_value), .rsp_humidity_value(rsp_humidity_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   hts_sequencer_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_read_byte_high(req_read_byte_high), .req_read_byte_low(req_read_byte_low),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_kind(rsp_result_kind),
      .rsp_xfer_is_read(rsp_xfer_is_read), .rsp_xfer_length(rsp_xfer_length),
      .rsp_xfer_address(rsp_xfer_address), .rsp_xfer_command(rsp_xfer_command),
      .rsp_xfer_register_value(rsp_xfer_register_value),
      .rsp_temperature_value(rsp_temperature_value), .rsp_humidity_value(rsp_humidity_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding), .item_count(item_count),
      .reply_count(reply_count), .meas_count(meas_count), .busy_count(busy_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side backpressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Present one item after an optional random gap and hold it until accepted.
   task automatic send_item(input req_kind_type kind, input logic [7:0] hi,
                            input logic [7:0] lo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_read_byte_high <= hi;
      req_read_byte_low  <= lo;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sent_items++;
   endtask

   // Stray requests that land in the middle of a sequence.
   task automatic stray_items();
      while ($urandom_range(99) < noise_pct)
         send_item(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
   endtask

   // Hold off the sender until every predicted result has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      drain_replies();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
   endtask

   // Measure request followed by its four completions.
   task automatic run_measure(input logic [7:0] t_hi, input logic [7:0] t_lo,
                              input logic [7:0] h_hi, input logic [7:0] h_lo);
      send_item(REQ_MEASURE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, t_hi, t_lo);
      stray_items();
      send_item(REQ_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, h_hi, h_lo);
   endtask

   // Configure request: register read command, register read, register write.
   task automatic run_configure(input logic [7:0] reg_now);
      send_item(REQ_CONFIGURE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, reg_now, 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic run_device_reset();
      send_item(REQ_RESET, 8'($urandom_range(255)), 8'($urandom_range(255)));
      stray_items();
      send_item(REQ_COMPLETE, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   initial begin
      int phase;
      int seg;
      int pick;
      int goal;
      logic [6:0] addr_pick;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_type           <= REQ_RESET;
      req_read_byte_high <= 8'd0;
      req_read_byte_low  <= 8'd0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      send_idle_pct = 33;
      recv_idle_pct = 74;
      noise_pct     = 0;
      sent_items    = 0;
      csr_writes    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: completion while idle, then readings at the low end of the range.
      send_item(REQ_COMPLETE, 8'hFF, 8'hFF);
      run_measure(8'h00, 8'h00, 8'h00, 8'h03);

      // Full-scale measurement with requests arriving while busy.
      send_item(REQ_MEASURE, 8'h00, 8'h00);
      send_item(REQ_CONFIGURE, 8'hFF, 8'hFF);
      send_item(REQ_RESET, 8'hA5, 8'h5A);
      send_item(REQ_MEASURE, 8'h00, 8'h00);
      send_item(REQ_COMPLETE, 8'h00, 8'h00);
      send_item(REQ_COMPLETE, 8'hFF, 8'hFF);
      send_item(REQ_COMPLETE, 8'h00, 8'h00);
      send_item(REQ_COMPLETE, 8'hFF, 8'hFF);

      // Resolution bits into a cleared and into a full user register.
      write_register(RES_ADDR, 32'd3);
      write_register(DEV_ADDR, 32'd127);
      run_configure(8'h00);
      write_register(RES_ADDR, 32'hFFFF_FFFC);
      write_register(DEV_ADDR, 32'hFFFF_FF80);
      run_configure(8'hFF);
      run_device_reset();

      // Random sequences under three pacing mixes, each with a few register settings.
      noise_pct = 8;
      goal = sent_items;
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 74 : 0;
         recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 33 : 0;
         for (seg = 0; seg < 3; seg++) begin
            addr_pick = (seg == 0) ? 7'd0 : (seg == 1) ? 7'd127 : 7'($urandom_range(127));
            write_register(RES_ADDR, {30'($urandom_range(32'h3FFF_FFFF)),
                                      2'((phase * 3 + seg) % 4)});
            write_register(DEV_ADDR, {25'($urandom), addr_pick});
            goal += RANDOM_ITEMS / 9;
            while (sent_items < goal) begin
               pick = $urandom_range(99);
               if (pick < 55)
                  run_measure(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
               else if (pick < 80)
                  run_configure(8'($urandom_range(255)));
               else if (pick < 90)
                  run_device_reset();
               else
                  send_item(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
            end
         end
      end

      drain_replies();
      $display("Checked %0d results for %0d items: %0d finished measurements, %0d busy rejections.",
               reply_count, item_count, meas_count, busy_count);
      $display("Three pacing mixes, %0d register writes over all resolution modes and address extremes.",
               csr_writes);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
